### rtl/frame_dirty_chunk_run_coalescer_defines.svh
// ------------------------------------------------------------------------
// frame dirty chunk run coalescer assertion macros
// shared property forms for the port-level checker
// ------------------------------------------------------------------------
`ifndef FRAME_DIRTY_CHUNK_RUN_COALESCER_DEFINES_SVH
`define FRAME_DIRTY_CHUNK_RUN_COALESCER_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define FDCRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define FDCRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fdcrc_pkg.sv
// ------------------------------------------------------------------------
// fdcrc_pkg
// shared constants and types of the dirty chunk run coalescer
// ------------------------------------------------------------------------
package fdcrc_pkg;

   localparam int WORD_W          = 64;
   localparam int CHUNK_BYTES     = 32;
   localparam int MAX_CHUNKS      = 1048576;
   localparam int HEADER_BYTES    = 20;
   localparam int FRAME_CHUNKS_W  = 21;
   localparam int FRAME_CHUNKS_RESET = 259200;
   localparam int OFS_W           = 25;
   localparam int LEN_W           = 26;

   localparam int WORDS_PER_CHUNK = (CHUNK_BYTES / 8) < 1 ? 1 : (CHUNK_BYTES / 8);
   localparam int WORD_IDX_W      = (WORDS_PER_CHUNK > 1) ? $clog2(WORDS_PER_CHUNK) : 1;
   localparam int CHUNK_SHIFT     = $clog2(CHUNK_BYTES);
   localparam int CHUNK_IDX_W     = FRAME_CHUNKS_W;
   localparam int OFS_FULL_W      = CHUNK_IDX_W + CHUNK_SHIFT;

   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 4;

   typedef enum logic [0:0] {
      REG_DEST_BASE    = 1'b0,
      REG_FRAME_CHUNKS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [WORD_W-1:0]         dest_base;
      logic [FRAME_CHUNKS_W-1:0] frame_chunks;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] run_dest_address;
      logic [OFS_W-1:0]  run_source_offset;
      logic [LEN_W-1:0]  run_length_bytes;
      logic              frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } rsp_item_type;

endpackage

### rtl/fdcrc_req_if.sv
// ------------------------------------------------------------------------
// fdcrc_req_if
// input channel: current and previous frame word pair
// ------------------------------------------------------------------------
interface fdcrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [fdcrc_pkg::WORD_W-1:0] current_word;
   logic [fdcrc_pkg::WORD_W-1:0] previous_word;

   modport source (output valid, output current_word, output previous_word, input ready);
   modport sink   (input valid, input current_word, input previous_word, output ready);
endinterface

### rtl/fdcrc_rsp_if.sv
// ------------------------------------------------------------------------
// fdcrc_rsp_if
// result channel: one coalesced dirty run
// ------------------------------------------------------------------------
interface fdcrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fdcrc_pkg::WORD_W-1:0] run_dest_address;
   logic [fdcrc_pkg::OFS_W-1:0]  run_source_offset;
   logic [fdcrc_pkg::LEN_W-1:0]  run_length_bytes;
   logic                          frame_end;

   modport source (output valid, output run_dest_address, output run_source_offset,
                   output run_length_bytes, output frame_end, input ready);
   modport sink   (input valid, input run_dest_address, input run_source_offset,
                   input run_length_bytes, input frame_end, output ready);
endinterface

### rtl/frame_dirty_chunk_run_coalescer.sv
// an item's result passes the input register, then the result register;
// items with no result are absorbed
// throughput: one word pair per cycle unless a result waits for the result
// register; set by the run update between the input and result registers
// reset: synchronous, clears the stream state and both valid flags;
// dest_base returns to 0 and frame_chunks to 259200
// ------------------------------------------------------------------------
// frame_dirty_chunk_run_coalescer
// compares frame word pairs per chunk and emits merged dirty chunk runs
// ------------------------------------------------------------------------
module frame_dirty_chunk_run_coalescer (
   input  logic                              clock,
   input  logic                              reset,
   fdcrc_req_if.sink                         req_chan,
   fdcrc_rsp_if.source                       rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdcrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fdcrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fdcrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);

   fdcrc_pkg::cfg_type         cfg;
   fdcrc_pkg::rsp_item_type    rsp_item;
   fdcrc_pkg::rsp_payload_type rsp_data;
   logic                       out_free;
   logic                       req_ready;
   logic                       rsp_valid;

   fdcrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fdcrc_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_chan.valid),
      .req_ready     (req_ready),
      .current_word  (req_chan.current_word),
      .previous_word (req_chan.previous_word),
      .rsp_item      (rsp_item),
      .out_free      (out_free)
   );

   fdcrc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .rsp_item  (rsp_item),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   assign req_chan.ready             = req_ready;
   assign rsp_chan.valid             = rsp_valid;
   assign rsp_chan.run_dest_address  = rsp_data.run_dest_address;
   assign rsp_chan.run_source_offset = rsp_data.run_source_offset;
   assign rsp_chan.run_length_bytes  = rsp_data.run_length_bytes;
   assign rsp_chan.frame_end         = rsp_data.frame_end;

endmodule

### rtl/fdcrc_csr.sv
// ------------------------------------------------------------------------
// fdcrc_csr
// apb register file: destination base and frame size
// ------------------------------------------------------------------------
module fdcrc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fdcrc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fdcrc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fdcrc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready,
   output fdcrc_pkg::cfg_type                cfg
);

   fdcrc_pkg::cfg_type      cfg_ff;
   fdcrc_pkg::cfg_type      cfg_in;
   fdcrc_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   // registers sit on 8-byte boundaries
   assign reg_sel = fdcrc_pkg::reg_index_type'(paddr[3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            fdcrc_pkg::REG_DEST_BASE: cfg_in.dest_base = pwdata;
            fdcrc_pkg::REG_FRAME_CHUNKS:
               cfg_in.frame_chunks = pwdata[fdcrc_pkg::FRAME_CHUNKS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         fdcrc_pkg::REG_DEST_BASE: prdata = cfg_ff.dest_base;
         fdcrc_pkg::REG_FRAME_CHUNKS:
            prdata = fdcrc_pkg::CSR_DATA_W'(cfg_ff.frame_chunks);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_base    <= '0;
         cfg_ff.frame_chunks <= fdcrc_pkg::FRAME_CHUNKS_W'(fdcrc_pkg::FRAME_CHUNKS_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/fdcrc_tracker.sv
// ------------------------------------------------------------------------
// fdcrc_tracker
// input register, chunk/run tracking and result formation
// ------------------------------------------------------------------------
module fdcrc_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  fdcrc_pkg::cfg_type            cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fdcrc_pkg::WORD_W-1:0] current_word,
   input  logic [fdcrc_pkg::WORD_W-1:0] previous_word,
   output fdcrc_pkg::rsp_item_type       rsp_item,
   input  logic                          out_free
);

   localparam int IW = fdcrc_pkg::CHUNK_IDX_W;
   localparam int WW = fdcrc_pkg::WORD_IDX_W;
   localparam logic [WW-1:0] WORD_LAST = WW'(fdcrc_pkg::WORDS_PER_CHUNK - 1);
   localparam logic [IW-1:0] MAX_IDX   = IW'(fdcrc_pkg::MAX_CHUNKS);

   // input register
   logic          in_valid_ff, in_valid_in;
   logic          in_diff_ff, in_diff_in;

   // stream state
   logic [WW-1:0] word_in_chunk_ff, word_in_chunk_in;
   logic [IW-1:0] chunk_index_ff, chunk_index_in;
   logic          chunk_differs_ff, chunk_differs_in;
   logic          run_open_ff, run_open_in;
   logic [IW-1:0] run_start_ff, run_start_in;
   logic [IW-1:0] run_count_ff, run_count_in;

   logic          req_take, in_fire, emit, differs, chunk_done, last;
   logic [IW-1:0] eff_chunks, new_start, new_count;
   logic [fdcrc_pkg::OFS_FULL_W-1:0] ofs_full, len_full;

   assign differs    = chunk_differs_ff | in_diff_ff;
   assign chunk_done = (word_in_chunk_ff == WORD_LAST);

   always_comb begin
      if (cfg.frame_chunks == '0) begin
         eff_chunks = IW'(1);
      end else if (cfg.frame_chunks > MAX_IDX) begin
         eff_chunks = MAX_IDX;
      end else begin
         eff_chunks = cfg.frame_chunks;
      end
   end

   assign last = ({1'b0, chunk_index_ff} + (IW+1)'(1)) >= {1'b0, eff_chunks};

   // run bounds after this chunk is folded in
   always_comb begin
      new_start = run_start_ff;
      new_count = run_count_ff;
      if (differs) begin
         if (run_open_ff) begin
            new_count = run_count_ff + IW'(1);
         end else begin
            new_start = chunk_index_ff;
            new_count = IW'(1);
         end
      end
   end

   assign emit = chunk_done && (differs ? last : run_open_ff);

   assign in_fire   = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || in_fire;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in = req_take ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
   assign in_diff_in  = req_take ? (current_word != previous_word) : in_diff_ff;

   assign ofs_full = fdcrc_pkg::OFS_FULL_W'(new_start) << fdcrc_pkg::CHUNK_SHIFT;
   assign len_full = fdcrc_pkg::OFS_FULL_W'(new_count) << fdcrc_pkg::CHUNK_SHIFT;

   always_comb begin
      rsp_item.valid                  = in_valid_ff && emit;
      rsp_item.data.run_dest_address  = cfg.dest_base
                                        + fdcrc_pkg::WORD_W'(fdcrc_pkg::HEADER_BYTES)
                                        + fdcrc_pkg::WORD_W'(ofs_full);
      rsp_item.data.run_source_offset = ofs_full[fdcrc_pkg::OFS_W-1:0];
      rsp_item.data.run_length_bytes  = len_full[fdcrc_pkg::LEN_W-1:0];
      rsp_item.data.frame_end         = last;
   end

   always_comb begin
      word_in_chunk_in = word_in_chunk_ff;
      chunk_index_in   = chunk_index_ff;
      chunk_differs_in = chunk_differs_ff;
      run_open_in      = run_open_ff;
      run_start_in     = run_start_ff;
      run_count_in     = run_count_ff;
      if (in_fire) begin
         if (!chunk_done) begin
            word_in_chunk_in = word_in_chunk_ff + WW'(1);
            chunk_differs_in = differs;
         end else begin
            word_in_chunk_in = '0;
            chunk_differs_in = 1'b0;
            if (last) begin
               // frame over: clear everything for the next one
               chunk_index_in = '0;
               run_open_in    = 1'b0;
               run_start_in   = '0;
               run_count_in   = '0;
            end else begin
               chunk_index_in = chunk_index_ff + IW'(1);
               run_open_in    = differs;
               run_start_in   = differs ? new_start : '0;
               run_count_in   = differs ? new_count : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         word_in_chunk_ff <= '0;
         chunk_index_ff   <= '0;
         chunk_differs_ff <= 1'b0;
         run_open_ff      <= 1'b0;
         run_start_ff     <= '0;
         run_count_ff     <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         word_in_chunk_ff <= word_in_chunk_in;
         chunk_index_ff   <= chunk_index_in;
         chunk_differs_ff <= chunk_differs_in;
         run_open_ff      <= run_open_in;
         run_start_ff     <= run_start_in;
         run_count_ff     <= run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_diff_ff <= in_diff_in;
   end

endmodule

### rtl/fdcrc_out_stage.sv
// ------------------------------------------------------------------------
// fdcrc_out_stage
// result register between run tracking and the result channel
// ------------------------------------------------------------------------
module fdcrc_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  fdcrc_pkg::rsp_item_type    rsp_item,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fdcrc_pkg::rsp_payload_type rsp_data
);

   logic                       out_valid_ff, out_valid_in;
   fdcrc_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                       load;

   assign out_free = !out_valid_ff || rsp_ready;
   assign load     = rsp_item.valid && out_free;

   assign out_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   assign out_data_in  = load ? rsp_item.data : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### rtl/fdcrc_checker.sv
// ------------------------------------------------------------------------
// fdcrc_checker
// port-level checks of the coalescer, bound to the top level
// ------------------------------------------------------------------------
`include "frame_dirty_chunk_run_coalescer_defines.svh"

module fdcrc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fdcrc_pkg::WORD_W-1:0]     run_dest_address,
   input logic [fdcrc_pkg::OFS_W-1:0]      run_source_offset,
   input logic [fdcrc_pkg::LEN_W-1:0]      run_length_bytes,
   input logic                              frame_end,
   input logic                              pready
);

   localparam int SH = fdcrc_pkg::CHUNK_SHIFT;

   // a stalled result must hold
   `FDCRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(run_dest_address) && $stable(run_source_offset) && $stable(run_length_bytes) && $stable(frame_end), "result changed while stalled")

   // runs cover whole chunks and at least one
   `FDCRC_ASSERT_NOW(a_run_aligned, clock, reset, rsp_valid, (run_source_offset[SH-1:0] == '0) && (run_length_bytes[SH-1:0] == '0) && (run_length_bytes != '0), "run not chunk aligned")

   // reset leaves no result pending
   `FDCRC_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   `FDCRC_ASSERT_NOW(a_pready_high, clock, reset, 1'b1, pready, "register port stalled")

endmodule

bind frame_dirty_chunk_run_coalescer fdcrc_checker u_fdcrc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .run_dest_address  (rsp_chan.run_dest_address),
   .run_source_offset (rsp_chan.run_source_offset),
   .run_length_bytes  (rsp_chan.run_length_bytes),
   .frame_end         (rsp_chan.frame_end),
   .pready            (pready)
);

### tb/fdcrc_run_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// fdcrc_run_checker
// watches the word pair, run and register ports of the coalescer, works
// out the dirty runs each accepted word pair closes and compares them in
// order with the runs the block emits
// ------------------------------------------------------------------------
module fdcrc_run_checker
   import fdcrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fdcrc_req_if                  req_chan,
   fdcrc_rsp_if                  rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatch_count,
   output int                    runs_pending
);

   cfg_type                  cfg;
   rsp_payload_type          run_expect_q[$];

   int unsigned              words_taken;
   logic [CHUNK_IDX_W-1:0]   chunk_idx;
   logic                     chunk_dirty;
   logic                     run_open;
   logic [CHUNK_IDX_W-1:0]   run_start;
   logic [CHUNK_IDX_W-1:0]   run_chunks;
   int                       err_total = 0;

   task automatic push_run(input logic at_end);
      rsp_payload_type run;
      logic [WORD_W-1:0] offset;
      offset = WORD_W'(run_start) * WORD_W'(CHUNK_BYTES);
      run.run_dest_address  = cfg.dest_base + WORD_W'(HEADER_BYTES) + offset;
      run.run_source_offset = offset[OFS_W-1:0];
      run.run_length_bytes  = LEN_W'(WORD_W'(run_chunks) * WORD_W'(CHUNK_BYTES));
      run.frame_end         = at_end;
      run_expect_q.push_back(run);
   endtask

   task automatic predict_runs(input logic [WORD_W-1:0] cur, input logic [WORD_W-1:0] prev);
      int unsigned limit;
      logic last;
      if (cur != prev) chunk_dirty = 1'b1;
      words_taken++;
      if (words_taken < WORDS_PER_CHUNK) return;
      words_taken = 0;

      // a size of zero behaves as one, oversized values saturate
      limit = (cfg.frame_chunks == '0) ? 1 : int'(cfg.frame_chunks);
      if (limit > MAX_CHUNKS) limit = MAX_CHUNKS;
      last = (int'(chunk_idx) + 1) >= limit;

      if (chunk_dirty) begin
         if (run_open) begin
            run_chunks++;
         end else begin
            run_open   = 1'b1;
            run_start  = chunk_idx;
            run_chunks = 1;
         end
         if (last) push_run(1'b1);
      end else if (run_open) begin
         push_run(last);
         run_open = 1'b0;
      end
      chunk_dirty = 1'b0;

      if (last) begin
         chunk_idx  = '0;
         run_open   = 1'b0;
         run_start  = '0;
         run_chunks = '0;
      end else begin
         chunk_idx++;
         if (!run_open) begin
            run_start  = '0;
            run_chunks = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         cfg.dest_base    = '0;
         cfg.frame_chunks = FRAME_CHUNKS_W'(FRAME_CHUNKS_RESET);
         words_taken      = 0;
         chunk_idx        = '0;
         chunk_dirty      = 1'b0;
         run_open         = 1'b0;
         run_start        = '0;
         run_chunks       = '0;
         run_expect_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (int'(paddr >> 3) == int'(REG_DEST_BASE))
               cfg.dest_base = pwdata[WORD_W-1:0];
            else if (int'(paddr >> 3) == int'(REG_FRAME_CHUNKS))
               cfg.frame_chunks = pwdata[FRAME_CHUNKS_W-1:0];
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            got.run_dest_address  = rsp_chan.run_dest_address;
            got.run_source_offset = rsp_chan.run_source_offset;
            got.run_length_bytes  = rsp_chan.run_length_bytes;
            got.frame_end         = rsp_chan.frame_end;
            if (run_expect_q.size() == 0) begin
               $error("unexpected run: address %h offset %h length %h frame_end %b",
                      got.run_dest_address, got.run_source_offset,
                      got.run_length_bytes, got.frame_end);
               err_total++;
            end else begin
               want = run_expect_q.pop_front();
               if (got.run_dest_address !== want.run_dest_address) begin
                  $error("run_dest_address: expected %h, got %h",
                         want.run_dest_address, got.run_dest_address);
                  err_total++;
               end
               if (got.run_source_offset !== want.run_source_offset) begin
                  $error("run_source_offset: expected %h, got %h",
                         want.run_source_offset, got.run_source_offset);
                  err_total++;
               end
               if (got.run_length_bytes !== want.run_length_bytes) begin
                  $error("run_length_bytes: expected %h, got %h",
                         want.run_length_bytes, got.run_length_bytes);
                  err_total++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
                  err_total++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready)
            predict_runs(req_chan.current_word, req_chan.previous_word);
      end
      mismatch_count <= err_total;
      runs_pending   <= run_expect_q.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// testbench
// drives frame word pairs and register writes into the dirty chunk run
// coalescer under several sizes, bases and idling patterns, and reports
// the outcome of the run checker
// ------------------------------------------------------------------------
module testbench;
   import fdcrc_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 6;
   localparam int HOLD_CYCLES   = 150;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {CHUNK_CLEAN, CHUNK_DIRTY, CHUNK_NOISE} chunk_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    mismatch_count;
   int                    runs_pending;
   int                    cycle_count = 0;
   int                    tx_idle_pct = 0;
   int                    rx_stall_pct = 0;
   int                    hold_token = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;

   fdcrc_req_if req_chan ();
   fdcrc_rsp_if rsp_chan ();

   frame_dirty_chunk_run_coalescer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   fdcrc_run_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .runs_pending   (runs_pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** frame_dirty_chunk_run_coalescer: FAILED **");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen      <= hold_token;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_pair(input logic [WORD_W-1:0] cur, input logic [WORD_W-1:0] prev);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.current_word  <= cur;
      req_chan.previous_word <= prev;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_chunk(input chunk_kind_type kind);
      logic [WORD_W-1:0] cur;
      logic [WORD_W-1:0] flip;
      int hit;
      hit = $urandom_range(0, WORDS_PER_CHUNK - 1);
      for (int w = 0; w < WORDS_PER_CHUNK; w++) begin
         cur  = random_word();
         flip = '0;
         if (kind == CHUNK_NOISE)
            flip = random_word();
         else if (kind == CHUNK_DIRTY && (w == hit || $urandom_range(0, 3) == 0))
            flip = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63)) : random_word();
         send_pair(cur, cur ^ flip);
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // wait for every outstanding run, then let absorbed items clear the pipe
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (runs_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      tx_idle_pct  = (mode == IDLE_SENDER) ? 56 : (mode == IDLE_BOTH) ? 12 : 0;
      rx_stall_pct <= (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 12 : 0;
   endtask

   task automatic run_phase(input logic [WORD_W-1:0] base, input logic [CSR_DATA_W-1:0] chunks,
                            input int n_chunks, input idle_mode_type mode);
      int pick;
      settle();
      write_reg(REG_DEST_BASE, base);
      write_reg(REG_FRAME_CHUNKS, chunks);
      set_idling(mode);
      repeat (n_chunks) begin
         pick = $urandom_range(0, 99);
         send_chunk(pick < 45 ? CHUNK_CLEAN : pick < 90 ? CHUNK_DIRTY : CHUNK_NOISE);
      end
   endtask

   initial begin
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_chan.valid         = 1'b0;
      req_chan.current_word  = '0;
      req_chan.previous_word = '0;
      rsp_chan.ready         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: equal extremes, full-width and single-bit differences
      repeat (WORDS_PER_CHUNK) send_pair('0, '0);
      repeat (WORDS_PER_CHUNK) send_pair('1, '1);
      repeat (WORDS_PER_CHUNK) send_pair('1, '0);
      for (int w = 0; w < WORDS_PER_CHUNK; w++)
         send_pair(64'h5555_aaaa_0f0f_f0f0, (w == WORDS_PER_CHUNK - 1) ?
                   64'h5555_aaaa_0f0f_f0f1 : 64'h5555_aaaa_0f0f_f0f0);
      for (int w = 0; w < WORDS_PER_CHUNK; w++)
         send_pair(64'h8000_0000_0000_0000, (w == 0) ? 64'h0 : 64'h8000_0000_0000_0000);
      // clean chunk closes the run opened above
      repeat (WORDS_PER_CHUNK) send_pair(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);

      // shrinking the size under a running frame ends it at the next chunk
      run_phase('0, 1, 20, IDLE_NONE);
      run_phase('1, 0, 20, IDLE_SENDER);
      run_phase(64'hffff_ffff_ffff_ffeb, 3, 24, IDLE_RECEIVER);
      run_phase(random_word(), 2, 24, IDLE_BOTH);
      run_phase(random_word(), MAX_CHUNKS, 24, IDLE_NONE);
      run_phase(random_word(), '1, 24, IDLE_SENDER);
      run_phase(random_word(), 4, 24, IDLE_RECEIVER);
      for (int p = 0; p < 9; p++)
         run_phase(random_word(), $urandom_range(1, 12), 16, idle_mode_type'(p % 4));

      // long receiver hold-off while dirty and clean chunks alternate
      settle();
      write_reg(REG_DEST_BASE, random_word());
      write_reg(REG_FRAME_CHUNKS, 9);
      set_idling(IDLE_NONE);
      hold_token <= hold_token + 1;
      for (int c = 0; c < 40; c++)
         send_chunk(c % 2 ? CHUNK_CLEAN : CHUNK_DIRTY);

      settle();
      if (mismatch_count == 0 && runs_pending == 0) begin
         $display("** frame_dirty_chunk_run_coalescer: PASSED **");
      end else begin
         $display("** frame_dirty_chunk_run_coalescer: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/fdcrc_pkg.sv
rtl/fdcrc_req_if.sv
rtl/fdcrc_rsp_if.sv
rtl/fdcrc_csr.sv
rtl/fdcrc_tracker.sv
rtl/fdcrc_out_stage.sv
rtl/frame_dirty_chunk_run_coalescer.sv
rtl/fdcrc_checker.sv
tb/fdcrc_run_checker.sv
tb/testbench.sv
